### hw/rtl/fragment_deframer_length_flag_unit_defines.svh
// Assertion macros shared by the fragment deframer RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FRAGMENT_DEFRAMER_LENGTH_FLAG_UNIT_DEFINES_SVH
`define FRAGMENT_DEFRAMER_LENGTH_FLAG_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDLF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/fdlf_pkg.sv
// Package for the fragment deframer: field widths, constants and the result word type.
// Has no dependencies; used by every module of the block.
`default_nettype none

package fdlf_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 31;
  localparam int CNT_W  = 32;
  localparam int SHIFT_W = 24;

  localparam logic [1:0]        HDR_LAST      = 2'd3;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 31'd4096;
  localparam logic [CNT_W-1:0]  CNT_MAX       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              message_end;
    logic [CNT_W-1:0]  message_length;
    logic              length_error;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/fdlf_step.sv
// Deframing state and the single-pass update for one received byte.
// Depends on fdlf_pkg for widths and the result word type.
`default_nettype none

module fdlf_step
  import fdlf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [LEN_W-1:0]  max_len,
  output result_t                res,
  output logic                   res_valid
);

  logic               in_payload, in_payload_next;
  logic [1:0]         header_count, header_count_next;
  logic [SHIFT_W-1:0] header_shift, header_shift_next;
  logic [LEN_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic               more_fragments, more_fragments_next;
  logic [CNT_W-1:0]   message_count, message_count_next;

  logic [CNT_W-1:0]   hdr_word;
  logic [LEN_W-1:0]   hdr_len;
  logic [LEN_W-1:0]   rem_dec;
  logic [CNT_W-1:0]   cnt_inc;

  assign hdr_word = {header_shift, rx_byte};
  assign hdr_len  = hdr_word[CNT_W-1:1];
  assign rem_dec  = bytes_remaining - LEN_W'(1);
  assign cnt_inc  = (message_count == CNT_MAX) ? message_count : message_count + CNT_W'(1);

  always_comb begin
    in_payload_next      = in_payload;
    header_count_next    = header_count;
    header_shift_next    = header_shift;
    bytes_remaining_next = bytes_remaining;
    more_fragments_next  = more_fragments;
    message_count_next   = message_count;
    res                  = '0;
    res_valid            = 1'b0;
    if (go) begin
      if (!in_payload) begin
        if (header_count != HDR_LAST) begin
          header_shift_next = {header_shift[SHIFT_W-BYTE_W-1:0], rx_byte};
          header_count_next = header_count + 2'd1;
        end else begin
          header_count_next = '0;
          header_shift_next = '0;
          if (hdr_len > max_len) begin
            res.length_error   = 1'b1;
            res.message_length = message_count;
            res_valid          = 1'b1;
            message_count_next = '0;
          end else if (hdr_len == '0) begin
            // An empty middle fragment is skipped silently.
            if (!hdr_word[0]) begin
              res.message_end    = 1'b1;
              res.message_length = message_count;
              res_valid          = 1'b1;
              message_count_next = '0;
            end
          end else begin
            in_payload_next      = 1'b1;
            bytes_remaining_next = hdr_len;
            more_fragments_next  = hdr_word[0];
          end
        end
      end else begin
        res.payload_byte     = rx_byte;
        res.payload_valid    = 1'b1;
        res.message_length   = cnt_inc;
        res_valid            = 1'b1;
        bytes_remaining_next = rem_dec;
        message_count_next   = cnt_inc;
        if (rem_dec == '0) begin
          in_payload_next = 1'b0;
          if (!more_fragments) begin
            res.message_end    = 1'b1;
            message_count_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      header_count    <= '0;
      header_shift    <= '0;
      bytes_remaining <= '0;
      more_fragments  <= 1'b0;
      message_count   <= '0;
    end else begin
      in_payload      <= in_payload_next;
      header_count    <= header_count_next;
      header_shift    <= header_shift_next;
      bytes_remaining <= bytes_remaining_next;
      more_fragments  <= more_fragments_next;
      message_count   <= message_count_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fdlf_out_queue.sv
// Two-word result queue that separates the output handshake from the update stage.
// Depends on fdlf_pkg for the result word type.
`default_nettype none

module fdlf_out_queue
  import fdlf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  result_t      push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fragment_deframer_length_flag_unit.sv
// Fragment deframer with length and more-fragments flag. It takes one received byte per
// clock while in_stall is low: a 4-byte big-endian header per fragment (length in bits
// 31..1, more-fragments flag in bit 0), then the payload bytes, each of which leaves as a
// word with the saturating message byte count. A byte is captured in an input register,
// processed once the output queue has room for its result, and its result, if any, written
// to a two-word output queue. One byte is accepted every cycle unless in_stall is high;
// in_stall rises only while the input register holds a byte and the output queue is full.
// Lengths above max_len produce an error word and the message is dropped. Depends on
// fdlf_pkg, fdlf_step, fdlf_out_queue and the assertion macro header.
`default_nettype none

`include "fragment_deframer_length_flag_unit_defines.svh"

module fragment_deframer_length_flag_unit
  import fdlf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write_en,
  input  wire logic [LEN_W-1:0]  cfg_write_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      payload_byte,
  output logic                   payload_valid,
  output logic                   message_end,
  output logic [CNT_W-1:0]       message_length,
  output logic                   length_error
);

  logic [LEN_W-1:0]  max_len;
  logic              r_valid;
  logic [BYTE_W-1:0] r_byte;
  logic              fire;
  logic              q_full;
  result_t           step_res;
  logic              step_res_valid;
  result_t           q_data;

  // The held byte is processed whenever the queue has room for its result.
  assign fire     = r_valid && !q_full;
  assign in_stall = r_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_write_en) begin
      max_len <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!in_stall) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      r_byte <= rx_byte;
    end
  end

  fdlf_step u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (fire),
    .rx_byte   (r_byte),
    .max_len   (max_len),
    .res       (step_res),
    .res_valid (step_res_valid)
  );

  fdlf_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step_res_valid),
    .push_data (step_res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data)
  );

  assign payload_byte   = q_data.payload_byte;
  assign payload_valid  = q_data.payload_valid;
  assign message_end    = q_data.message_end;
  assign message_length = q_data.message_length;
  assign length_error   = q_data.length_error;

  `FDLF_ASSERT_SAME(a_no_push_when_full, step_res_valid, !q_full, "result pushed into a full queue")
  `FDLF_ASSERT_NEXT(a_held_byte_kept, r_valid && !fire, r_valid, "held byte lost while stalled")
  `FDLF_ASSERT_SAME(a_err_not_end, out_valid, !(length_error && message_end), "error word also marked as message end")
  `FDLF_ASSERT_SAME(a_end_has_length, out_valid && message_end && payload_valid, message_length != '0, "message end byte with zero count")

endmodule

`default_nettype wire
